// ===== hw/rtl/rfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_pkg
// shared constants, codes and types of the remote frame checker
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int NUM_FIELDS  = 6;

    localparam logic [7:0] HDR0 = 8'h01;
    localparam logic [7:0] HDR1 = 8'h03;
    localparam logic [7:0] HDR3 = 8'h11;

    localparam logic [POS_W-1:0] POS_HDR0 = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR1 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_HDR3 = POS_W'(3);
    localparam logic [POS_W-1:0] POS_SUM  = POS_W'(15);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(FRAME_BYTES);

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_HEADER   = 2'd1,
        ERR_CHECKSUM = 2'd2,
        ERR_LENGTH   = 2'd3
    } t_err_code;

    typedef logic [7:0] t_fields [NUM_FIELDS];

    typedef struct packed {
        logic      done;
        logic      ok;
        t_err_code err;
    } t_verdict;

    // rolling code at byte 2, then joystick axes and buttons at bytes 4 to 8
    function automatic logic [POS_W-1:0] field_pos(input int idx);
        logic [POS_W-1:0] pos;
        if (idx == 0) begin
            pos = POS_W'(2);
        end else begin
            pos = POS_W'(idx + 3);
        end
        return pos;
    endfunction

endpackage

// ===== hw/rtl/rfc_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc item and result channels
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface rfc_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, func, data_byte, frame_last, input ready);
    modport sink   (input valid, func, data_byte, frame_last, output ready);
endinterface

interface rfc_result_if;
    logic       valid;
    logic       ready;
    logic       frame_done;
    logic       frame_ok;
    logic [1:0] error_code;
    logic [7:0] seq_code;
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic [7:0] left_x;
    logic [7:0] left_y;
    logic [7:0] buttons;
    logic       online;

    modport source (output valid, frame_done, frame_ok, error_code, seq_code,
                    right_x, right_y, left_x, left_y, buttons, online, input ready);
    modport sink   (input valid, frame_done, frame_ok, error_code, seq_code,
                    right_x, right_y, left_x, left_y, buttons, online, output ready);
endinterface

// ===== hw/rtl/rfc_frame_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_frame_check
// frame assembly, running checksum, header check and verdict per byte
// ----------------------------------------------------------------------------
module rfc_frame_check
    import rfc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  logic     i_last,
    input  logic [7:0] i_data,
    output t_verdict o_verdict,
    output t_fields  o_fields
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic             r_hdr, n_hdr;
    logic [7:0]       r_seen, n_seen;
    t_fields          r_pend, n_pend;
    logic             length_good;

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_hdr  = r_hdr;
        n_seen = r_seen;
        n_pend = r_pend;
        if (r_pos >= POS_FULL) begin
            n_pos = POS_FULL;
        end else begin
            if (r_pos < POS_SUM) begin
                n_sum = r_sum + i_data;
            end
            if ((r_pos == POS_HDR0 && i_data != HDR0) ||
                (r_pos == POS_HDR1 && i_data != HDR1) ||
                (r_pos == POS_HDR3 && i_data != HDR3)) begin
                n_hdr = 1'b0;
            end
            for (int i = 0; i < NUM_FIELDS; i++) begin
                if (r_pos == field_pos(i)) begin
                    n_pend[i] = i_data;
                end
            end
            if (r_pos == POS_SUM) begin
                n_seen = i_data;
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    assign length_good = (r_pos == POS_LAST);

    always_comb begin
        o_verdict.done = i_take && i_last;
        o_verdict.err  = ERR_OK;
        if (o_verdict.done) begin
            if (!length_good) begin
                o_verdict.err = ERR_LENGTH;
            end else if (!n_hdr) begin
                o_verdict.err = ERR_HEADER;
            end else if (n_sum != n_seen) begin
                o_verdict.err = ERR_CHECKSUM;
            end
        end
        o_verdict.ok = o_verdict.done && (o_verdict.err == ERR_OK);
    end

    assign o_fields = n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_hdr  <= 1'b1;
            r_seen <= '0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_pend[i] <= '0;
            end
        end else if (i_take) begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_hdr  <= n_hdr;
            r_seen <= n_seen;
            r_pend <= n_pend;
        end
    end

endmodule

// ===== hw/rtl/remote_frame_check_and_link_watch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_frame_check_and_link_watch
// remote-control frame checker with link watchdog
// ----------------------------------------------------------------------------
// Every item, payload byte or millisecond tick, gives exactly one result, and
// one item is taken every clock cycle: the frame state, checksum and verdict
// are settled in the cycle of the transfer and the result sits in an output
// register, valid in the next cycle, and input ready only drops while a
// finished result is stalled at the output. A frame passes when it has
// FRAME_BYTES bytes, the header bytes are right and byte 15 matches the
// running sum; a good frame refreshes the held fields and restarts the tick
// count. The timeout register may be written at any time the block is idle.
module remote_frame_check_and_link_watch
    import rfc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    rfc_item_if.sink     i_item,
    rfc_result_if.source o_result
);

    logic        take, take_byte, take_tick;
    t_verdict    verdict;
    t_fields     pend_fields;
    t_fields     r_held, n_held;
    logic [15:0] r_timeout;
    logic [15:0] r_ticks, n_ticks;
    logic        r_ever, n_ever;
    logic        n_online;

    logic        r_valid;
    logic        r_done, r_ok, r_online;
    logic [1:0]  r_err;

    assign i_item.ready = !r_valid || o_result.ready;
    assign take      = i_item.valid && i_item.ready;
    assign take_byte = take && (i_item.func == FUNC_BYTE);
    assign take_tick = take && (i_item.func == FUNC_TICK);

    rfc_frame_check u_frame_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take_byte),
        .i_last    (i_item.frame_last),
        .i_data    (i_item.data_byte),
        .o_verdict (verdict),
        .o_fields  (pend_fields)
    );

    always_comb begin
        n_ticks = r_ticks;
        n_ever  = r_ever;
        n_held  = r_held;
        if (take_tick && (r_ticks < r_timeout)) begin
            n_ticks = r_ticks + 16'd1;
        end
        if (verdict.ok) begin
            n_ticks = '0;
            n_ever  = 1'b1;
            n_held  = pend_fields;
        end
        n_online = n_ever && (n_ticks < r_timeout);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
            r_ever  <= 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_held[i] <= '0;
            end
        end else if (take) begin
            r_ticks <= n_ticks;
            r_ever  <= n_ever;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_done   <= verdict.done;
            r_ok     <= verdict.ok;
            r_err    <= verdict.err;
            r_online <= n_online;
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.frame_done   = r_done;
    assign o_result.frame_ok     = r_ok;
    assign o_result.error_code   = r_err;
    assign o_result.seq_code     = r_held[0];
    assign o_result.right_x      = r_held[1];
    assign o_result.right_y      = r_held[2];
    assign o_result.left_x       = r_held[3];
    assign o_result.left_y       = r_held[4];
    assign o_result.buttons      = r_held[5];
    assign o_result.online       = r_online;

endmodule

// ===== hw/rtl/rfc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_checker
// port-level checks of the remote frame checker, bound to the top level
// ----------------------------------------------------------------------------
module rfc_checker
    import rfc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_frame_done,
    input logic       i_frame_ok,
    input logic [1:0] i_error_code,
    input logic       i_online
);

    // stalled result keeps its verdict
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_frame_done) && $stable(i_frame_ok) &&
             $stable(i_error_code) && $stable(i_online)))
        else $error("stalled result changed");

    // every transfer in gives a result in the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("no result after input transfer");

    // empty output register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // verdict fields agree with each other
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_frame_ok == (i_frame_done && (i_error_code == ERR_OK))) &&
            (i_frame_done || (i_error_code == ERR_OK)))
        else $error("inconsistent verdict");

endmodule

bind remote_frame_check_and_link_watch rfc_checker u_rfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_frame_done (o_result.frame_done),
    .i_frame_ok   (o_result.frame_ok),
    .i_error_code (o_result.error_code),
    .i_online     (o_result.online)
);
